[design/sovc_pkg.sv]
// Shared types, register indexes and constants of the shape overlay compositor.
// Used by every module of the block; depends on nothing else.
package sovc_pkg;

    // Default screen size.
    localparam int SCREEN_W_DEF = 512;
    localparam int SCREEN_H_DEF = 512;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_A      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_B      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_COLOR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY     = 3'd6;

    // Alpha and coverage constants.
    localparam logic [7:0] ALPHA_FULL     = 8'd255;
    localparam logic [7:0] ALPHA_CORE     = 8'd220;
    localparam logic [7:0] ALPHA_RIM_BASE = 8'd180;
    localparam logic [7:0] TOP_OPAQUE     = 8'hFF;
    localparam int         RIM_SLOPE      = 40;

    // Rim divider sizing: gap is at most 2r+1, so the quotient never exceeds 40.
    localparam int GAP_W         = 11;
    localparam int DEN_W         = 11;
    localparam int NUM_W         = 17;
    localparam int QUO_W         = 6;
    localparam int QIDX_W        = $clog2(QUO_W);
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STEPS     = QUO_W / DIV_STEP_BITS;
    localparam int DIV_STAGES    = DIV_STEPS + 1;

    typedef enum logic [1:0] {
        MODE_RECT,
        MODE_AA_DISC,
        MODE_ALPHA_DISC,
        MODE_RING
    } mode_t;

    // How a pixel is covered by the shape.
    typedef enum logic [2:0] {
        COV_NONE,
        COV_SOLID,
        COV_OPACITY,
        COV_HALF,
        COV_CORE,
        COV_RIM
    } cov_kind_t;

    typedef struct packed {
        mode_t       mode;
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [10:0] size_a;
        logic [10:0] size_b;
        logic [31:0] shape_color;
        logic [7:0]  opacity;
    } cfg_t;

    // Geometry result handed to the rim divider.
    typedef struct packed {
        cov_kind_t        kind;
        logic [GAP_W-1:0] gap;
        logic [DEN_W-1:0] den;
        logic [31:0]      dest;
    } cov_t;

    // Divider result handed to the blender.
    typedef struct packed {
        cov_kind_t        kind;
        logic [QUO_W-1:0] quo;
        logic [31:0]      dest;
    } div_t;

endpackage

[design/shape_overlay_compositor.sv]
// Shape overlay compositor: per-pixel overlay of one configured shape.
//
// Usage:
//   Configuration: write registers through cfg_valid/cfg_ready with
//   cfg_index (0 mode, 1 pos_x, 2 pos_y, 3 size_a, 4 size_b, 5 shape_color,
//   6 opacity) and cfg_data. cfg_ready is always high; write only while no
//   pixel is in flight. Indexes beyond the list are ignored.
//   Pixels: one word per pixel on pixel_valid/pixel_ready carrying
//   pixel_x, pixel_y and dest_color. Each pixel returns one word on
//   result_valid/result_ready with out_color and touched, in order.
//   Depth: eleven register stages. Throughput: one pixel per clock while
//   the receiver keeps up. The rim coverage divider resolves two quotient
//   bits per stage over three stages, after a numerator load stage.
//   Stall: each stage holds its word only while the stage after it is full
//   and blocked, so empty stages keep filling; pixel_ready falls once the
//   whole pipeline is full behind an untaken result.
//   Reset: rst_n clears all valid bits and sets the registers to mode 0,
//   zero geometry and colour, opacity 255.
// Depends on sovc_pkg, sovc_geom, sovc_div and sovc_blend.
module shape_overlay_compositor #(
    parameter int SCREEN_W = sovc_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = sovc_pkg::SCREEN_H_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sovc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic [8:0]                     pixel_x,
    input  logic [8:0]                     pixel_y,
    input  logic [31:0]                    dest_color,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [31:0]                    out_color,
    output logic                           touched
);
    import sovc_pkg::*;

    mode_t       mode_reg;
    logic [10:0] pos_x_reg, pos_y_reg, size_a_reg, size_b_reg;
    logic [31:0] shape_color_reg;
    logic [7:0]  opacity_reg;
    cfg_t        cfg;

    logic cov_valid, geom_ready;
    logic div_valid, div_ready;
    cov_t cov;
    div_t div;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_RECT;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            size_a_reg      <= '0;
            size_b_reg      <= '0;
            shape_color_reg <= '0;
            opacity_reg     <= ALPHA_FULL;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:        mode_reg        <= mode_t'(cfg_data[1:0]);
                CFG_POS_X:       pos_x_reg       <= cfg_data[10:0];
                CFG_POS_Y:       pos_y_reg       <= cfg_data[10:0];
                CFG_SIZE_A:      size_a_reg      <= cfg_data[10:0];
                CFG_SIZE_B:      size_b_reg      <= cfg_data[10:0];
                CFG_SHAPE_COLOR: shape_color_reg <= cfg_data;
                CFG_OPACITY:     opacity_reg     <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.mode        = mode_reg;
        cfg.pos_x       = pos_x_reg;
        cfg.pos_y       = pos_y_reg;
        cfg.size_a      = size_a_reg;
        cfg.size_b      = size_b_reg;
        cfg.shape_color = shape_color_reg;
        cfg.opacity     = opacity_reg;
    end

    // Geometry, rim divider and blender in a row.
    sovc_geom #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_geom (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pixel_valid),
        .up_ready   (pixel_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .dest_color (dest_color),
        .cfg        (cfg),
        .cov_valid  (cov_valid),
        .down_ready (geom_ready),
        .cov        (cov)
    );

    sovc_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .cov_valid  (cov_valid),
        .up_ready   (geom_ready),
        .cov        (cov),
        .div_valid  (div_valid),
        .down_ready (div_ready),
        .div        (div)
    );

    sovc_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .div_valid    (div_valid),
        .up_ready     (div_ready),
        .div          (div),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_color    (out_color),
        .touched      (touched)
    );

`ifndef SYNTHESIS
    // The pixel side only stalls when a result is waiting and not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> result_valid && !result_ready)
        else $error("pixel input stalled without a blocked result");
`endif

endmodule

[design/sovc_geom.sv]
// Geometry pipeline: pixel offsets, squared distances and shape coverage class.
// Depends on sovc_pkg.
module sovc_geom #(
    parameter int SCREEN_W = sovc_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = sovc_pkg::SCREEN_H_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    output logic            up_ready,
    input  logic [8:0]      pixel_x,
    input  logic [8:0]      pixel_y,
    input  logic [31:0]     dest_color,
    input  sovc_pkg::cfg_t  cfg,
    output logic            cov_valid,
    input  logic            down_ready,
    output sovc_pkg::cov_t  cov
);
    import sovc_pkg::*;

    typedef struct packed {
        logic        onscreen;
        logic        in_rect;
        logic        centre;
        logic [11:0] dx;
        logic [11:0] dy;
        logic [31:0] dest;
    } s1_t;

    typedef struct packed {
        logic             onscreen;
        logic             in_rect;
        logic             centre;
        logic [21:0]      dx2;
        logic [21:0]      dy2;
        logic [19:0]      sa2;
        logic [19:0]      inner2;
        logic [20:0]      outer2;
        logic [21:0]      ri2;
        logic [DEN_W-1:0] den;
        logic [31:0]      dest;
    } s2_t;

    typedef struct packed {
        logic             onscreen;
        logic             in_rect;
        logic             centre;
        logic [22:0]      d2;
        logic [19:0]      sa2;
        logic [19:0]      inner2;
        logic [20:0]      outer2;
        logic [21:0]      ri2;
        logic [DEN_W-1:0] den;
        logic [31:0]      dest;
    } s3_t;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, cov_valid_reg;
    logic en1, en2, en3, en4;
    s1_t  s1_next, s1_reg;
    s2_t  s2_next, s2_reg;
    s3_t  s3_next, s3_reg;
    cov_t cov_next, cov_reg;

    logic signed [11:0] dx_c, dy_c, sa_s, sb_s, ri_s;
    logic signed [23:0] dx_sq, dy_sq;
    logic [9:0]         sa_u, sa_m1;
    logic [10:0]        sa_p1, ri_u;
    logic               sa_gt1;
    logic [19:0]        sa_sq, inner_sq;
    logic [21:0]        outer_sq, ri_sq;
    logic [22:0]        gap_diff;
    logic               sa_neg, sa_ge1, in_outer, in_inner, in_core, out_hole;

    // A stage may load when it is empty or its word moves on.
    assign en4      = !cov_valid_reg || down_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign up_ready = en1;

    // Stage 1: offsets from the shape origin, and the rectangle, centre and on-screen tests.
    assign sa_s = $signed({cfg.size_a[10], cfg.size_a});
    assign sb_s = $signed({cfg.size_b[10], cfg.size_b});
    assign dx_c = $signed({3'b000, pixel_x}) - $signed({cfg.pos_x[10], cfg.pos_x});
    assign dy_c = $signed({3'b000, pixel_y}) - $signed({cfg.pos_y[10], cfg.pos_y});

    always_comb
    begin
        s1_next.onscreen = (32'(pixel_x) < SCREEN_W) && (32'(pixel_y) < SCREEN_H);
        s1_next.in_rect  = !dx_c[11] && (dx_c < sa_s) && !dy_c[11] && (dy_c < sb_s);
        s1_next.centre   = (dx_c == 12'sd0) && (dy_c == 12'sd0);
        s1_next.dx       = dx_c;
        s1_next.dy       = dy_c;
        s1_next.dest     = dest_color;
    end

    // Stage 2: squares of the offsets and of the radii.
    assign sa_u   = cfg.size_a[9:0];
    assign sa_gt1 = !cfg.size_a[10] && (cfg.size_a[9:1] != 9'd0);
    assign sa_p1  = {1'b0, sa_u} + 11'd1;
    assign sa_m1  = sa_gt1 ? sa_u - 10'd1 : 10'd0;
    assign ri_s   = sa_s - sb_s;
    assign ri_u   = (!ri_s[11] && (ri_s != 12'sd0)) ? ri_s[10:0] : 11'd0;

    assign dx_sq    = $signed(s1_reg.dx) * $signed(s1_reg.dx);
    assign dy_sq    = $signed(s1_reg.dy) * $signed(s1_reg.dy);
    assign sa_sq    = sa_u * sa_u;
    assign inner_sq = sa_m1 * sa_m1;
    assign outer_sq = sa_p1 * sa_p1;
    assign ri_sq    = ri_u * ri_u;

    always_comb
    begin
        s2_next.onscreen = s1_reg.onscreen;
        s2_next.in_rect  = s1_reg.in_rect;
        s2_next.centre   = s1_reg.centre;
        s2_next.dx2      = dx_sq[21:0];
        s2_next.dy2      = dy_sq[21:0];
        s2_next.sa2      = sa_sq;
        s2_next.inner2   = inner_sq;
        s2_next.outer2   = outer_sq[20:0];
        s2_next.ri2      = ri_sq;
        s2_next.den      = {sa_u, 1'b1};
        s2_next.dest     = s1_reg.dest;
    end

    // Stage 3: squared distance from the centre.
    always_comb
    begin
        s3_next.onscreen = s2_reg.onscreen;
        s3_next.in_rect  = s2_reg.in_rect;
        s3_next.centre   = s2_reg.centre;
        s3_next.d2       = {1'b0, s2_reg.dx2} + {1'b0, s2_reg.dy2};
        s3_next.sa2      = s2_reg.sa2;
        s3_next.inner2   = s2_reg.inner2;
        s3_next.outer2   = s2_reg.outer2;
        s3_next.ri2      = s2_reg.ri2;
        s3_next.den      = s2_reg.den;
        s3_next.dest     = s2_reg.dest;
    end

    // Stage 4: radius compares and the coverage class of the pixel.
    assign sa_neg   = cfg.size_a[10];
    assign sa_ge1   = !sa_neg && (cfg.size_a != 11'd0);
    assign in_outer = s3_reg.d2 <= {2'b00, s3_reg.outer2};
    assign in_inner = s3_reg.d2 <= {3'b000, s3_reg.inner2};
    assign in_core  = s3_reg.d2 <= {3'b000, s3_reg.sa2};
    assign out_hole = s3_reg.d2 >= {1'b0, s3_reg.ri2};
    assign gap_diff = s3_reg.d2 - {3'b000, s3_reg.sa2};

    always_comb
    begin
        cov_next.kind = COV_NONE;
        unique case (cfg.mode)
            MODE_RECT:
            begin
                cov_next.kind = s3_reg.in_rect ? COV_OPACITY : COV_NONE;
            end
            MODE_AA_DISC:
            begin
                if (!sa_ge1)
                    cov_next.kind = s3_reg.centre ? COV_SOLID : COV_NONE;
                else if (in_inner)
                    cov_next.kind = COV_SOLID;
                else if (in_outer)
                    cov_next.kind = in_core ? COV_CORE : COV_RIM;
                else
                    cov_next.kind = COV_NONE;
            end
            MODE_ALPHA_DISC:
            begin
                if (!sa_ge1)
                    cov_next.kind = s3_reg.centre ? COV_OPACITY : COV_NONE;
                else if (in_outer)
                    cov_next.kind = in_core ? COV_OPACITY : COV_HALF;
                else
                    cov_next.kind = COV_NONE;
            end
            MODE_RING:
            begin
                cov_next.kind = (!sa_neg && in_core && out_hole) ? COV_SOLID : COV_NONE;
            end
        endcase
        if (!s3_reg.onscreen)
            cov_next.kind = COV_NONE;
        cov_next.gap  = gap_diff[GAP_W-1:0];
        cov_next.den  = s3_reg.den;
        cov_next.dest = s3_reg.dest;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            cov_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= pix_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                cov_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            s3_reg <= s3_next;
        if (en4)
            cov_reg <= cov_next;
    end

    assign cov_valid = cov_valid_reg;
    assign cov       = cov_reg;

`ifndef SYNTHESIS
    // A rim pixel lies strictly outside r*r, so its gap is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        cov_valid_reg && (cov_reg.kind == COV_RIM) |-> cov_reg.gap != '0)
        else $error("rim pixel with zero gap");
`endif

endmodule

[design/sovc_div.sv]
// Rim coverage divider: (gap * 40) / (2r + 1) by restoring division,
// two quotient bits per pipeline stage. Depends on sovc_pkg.
module sovc_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cov_valid,
    output logic           up_ready,
    input  sovc_pkg::cov_t cov,
    output logic           div_valid,
    input  logic           down_ready,
    output sovc_pkg::div_t div
);
    import sovc_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] en;
    logic [NUM_W-1:0]      rem_reg  [DIV_STAGES];
    logic [NUM_W-1:0]      rem_next [DIV_STAGES];
    logic [QUO_W-1:0]      quo_reg  [DIV_STAGES];
    logic [QUO_W-1:0]      quo_next [DIV_STAGES];
    logic [DEN_W-1:0]      den_reg  [DIV_STAGES];
    cov_kind_t             kind_reg [DIV_STAGES];
    logic [31:0]           dest_reg [DIV_STAGES];

    // Stall chain from the blender back to the geometry stages.
    always_comb
    begin
        en[LAST] = !valid_reg[LAST] || down_ready;
        for (int s = LAST - 1; s >= 0; s--)
            en[s] = !valid_reg[s] || en[s+1];
    end
    assign up_ready = en[0];

    // Numerator load, then conditional subtracts of the shifted divisor.
    always_comb
    begin : div_steps
        logic [NUM_W-1:0]  r;
        logic [NUM_W-1:0]  sub;
        logic [QUO_W-1:0]  q;
        logic [QIDX_W-1:0] bi;
        r   = '0;
        sub = '0;
        q   = '0;
        bi  = '0;
        rem_next[0] = NUM_W'(cov.gap) * NUM_W'(RIM_SLOPE);
        quo_next[0] = '0;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            r = rem_reg[s-1];
            q = quo_reg[s-1];
            for (int k = 0; k < DIV_STEP_BITS; k++)
            begin
                bi  = QIDX_W'(QUO_W - 1 - (s - 1) * DIV_STEP_BITS - k);
                sub = NUM_W'(den_reg[s-1]) << bi;
                if (r >= sub)
                begin
                    r     = r - sub;
                    q[bi] = 1'b1;
                end
            end
            rem_next[s] = r;
            quo_next[s] = q;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= cov_valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                if (en[s])
                    valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= quo_next[0];
            den_reg[0]  <= cov.den;
            kind_reg[0] <= cov.kind;
            dest_reg[0] <= cov.dest;
        end
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                den_reg[s]  <= den_reg[s-1];
                kind_reg[s] <= kind_reg[s-1];
                dest_reg[s] <= dest_reg[s-1];
            end
        end
    end

    assign div_valid = valid_reg[LAST];
    assign div.kind  = kind_reg[LAST];
    assign div.quo   = quo_reg[LAST];
    assign div.dest  = dest_reg[LAST];

`ifndef SYNTHESIS
    // The division of a rim word must finish with a remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && (kind_reg[LAST] == COV_RIM) |-> rem_reg[LAST] < NUM_W'(den_reg[LAST]))
        else $error("rim division left an oversized remainder");

    // Since gap is at most 2r+1, the rim loss never exceeds the slope.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && (kind_reg[LAST] == COV_RIM) |-> quo_reg[LAST] <= QUO_W'(RIM_SLOPE))
        else $error("rim quotient out of range");
`endif

endmodule

[design/sovc_blend.sv]
// Alpha selection and per-channel blend d + ((s - d) * a) / 255 with the
// output register of the block. Depends on sovc_pkg.
module sovc_blend (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           div_valid,
    output logic           up_ready,
    input  sovc_pkg::div_t div,
    input  sovc_pkg::cfg_t cfg,
    output logic           result_valid,
    input  logic           result_ready,
    output logic [31:0]    out_color,
    output logic           touched
);
    import sovc_pkg::*;

    logic        b0_valid_reg, b1_valid_reg, result_valid_reg;
    logic        en_b0, en_b1, en_out;

    logic [7:0]  a_next, a_reg;
    logic        hit_next, hit_reg;
    logic        full_next, full_reg;
    logic [31:0] dest0_reg;

    logic [15:0] prod_next [3];
    logic [15:0] prod_reg  [3];
    logic [2:0]  neg_next, neg_reg;
    logic        hit1_reg, full1_reg;
    logic [31:0] dest1_reg;

    logic [31:0] mixed;
    logic [31:0] out_color_next, out_color_reg;
    logic        touched_reg;

    assign en_out = !result_valid_reg || result_ready;
    assign en_b1  = !b1_valid_reg || en_out;
    assign en_b0  = !b0_valid_reg || en_b1;
    assign up_ready = en_b0;

    // Stage B0: alpha from the coverage class.
    always_comb
    begin
        unique case (div.kind)
            COV_SOLID:   a_next = ALPHA_FULL;
            COV_OPACITY: a_next = cfg.opacity;
            COV_HALF:    a_next = {1'b0, cfg.opacity[7:1]};
            COV_CORE:    a_next = ALPHA_CORE;
            COV_RIM:     a_next = ALPHA_RIM_BASE - {2'b00, div.quo};
            default:     a_next = 8'd0;
        endcase
        hit_next  = (div.kind != COV_NONE) && (a_next != 8'd0);
        full_next = (a_next == ALPHA_FULL);
    end

    // Stage B1: channel difference magnitude times alpha.
    always_comb
    begin : chan_mul
        logic [7:0] s_ch;
        logic [7:0] d_ch;
        logic [7:0] mag;
        s_ch = '0;
        d_ch = '0;
        mag  = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            s_ch         = cfg.shape_color[8*ch +: 8];
            d_ch         = dest0_reg[8*ch +: 8];
            neg_next[ch] = s_ch < d_ch;
            mag          = neg_next[ch] ? d_ch - s_ch : s_ch - d_ch;
            prod_next[ch] = mag * a_reg;
        end
    end

    // Stage B2: divide by 255 (exact for products up to 255 * 255), apply the sign and pick the colour.
    always_comb
    begin : chan_div
        logic [16:0] t;
        logic [7:0]  qt;
        logic [7:0]  d_ch;
        t     = '0;
        qt    = '0;
        d_ch  = '0;
        mixed = {TOP_OPAQUE, 24'd0};
        for (int ch = 0; ch < 3; ch++)
        begin
            t    = {1'b0, prod_reg[ch]} + 17'(prod_reg[ch][15:8]) + 17'd1;
            qt   = t[15:8];
            d_ch = dest1_reg[8*ch +: 8];
            mixed[8*ch +: 8] = neg_reg[ch] ? d_ch - qt : d_ch + qt;
        end
        if (full1_reg)
            out_color_next = cfg.shape_color;
        else if (hit1_reg)
            out_color_next = mixed;
        else
            out_color_next = dest1_reg;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg     <= 1'b0;
            b1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_b0)
                b0_valid_reg <= div_valid;
            if (en_b1)
                b1_valid_reg <= b0_valid_reg;
            if (en_out)
                result_valid_reg <= b1_valid_reg;
        end
    end

    // Stage payloads and the output word.
    always_ff @(posedge clk)
    begin
        if (en_b0)
        begin
            a_reg     <= a_next;
            hit_reg   <= hit_next;
            full_reg  <= full_next;
            dest0_reg <= div.dest;
        end
        if (en_b1)
        begin
            for (int ch = 0; ch < 3; ch++)
                prod_reg[ch] <= prod_next[ch];
            neg_reg   <= neg_next;
            hit1_reg  <= hit_reg;
            full1_reg <= full_reg;
            dest1_reg <= dest0_reg;
        end
        if (en_out)
        begin
            out_color_reg <= out_color_next;
            touched_reg   <= hit1_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_color    = out_color_reg;
    assign touched      = touched_reg;

`ifndef SYNTHESIS
    // Full alpha copies the shape colour, which only happens on a written pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        b0_valid_reg && full_reg |-> hit_reg)
        else $error("full alpha on an untouched pixel");
`endif

endmodule

[bench/shape_overlay_compositor_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the shape overlay compositor: drives pixel words and
// register writes, predicts every composed pixel and compares it field by field.
// Depends on sovc_pkg and the shape_overlay_compositor RTL.
module shape_overlay_compositor_test;
    import sovc_pkg::*;

    localparam int                   IDLE_LIMIT = 2000;
    localparam int                   ITEM_GOAL  = 1250;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [8:0]  x;
        logic [8:0]  y;
        logic [31:0] dest;
    } pixel_item_t;

    typedef struct {
        logic [31:0] color;
        logic        touched;
    } composed_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [31:0]          cfg_data     = '0;
    logic                 pixel_valid  = 1'b0;
    logic                 pixel_ready;
    logic [8:0]           pixel_x      = '0;
    logic [8:0]           pixel_y      = '0;
    logic [31:0]          dest_color   = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [31:0]          out_color;
    logic                 touched;

    // Shadow copy of the shape registers, updated as each write is taken.
    cfg_t        shape_cfg;
    pixel_item_t pixel_q[$];
    composed_t   composed_q[$];
    int          n_queued    = 0;
    int          n_taken     = 0;
    int          err_cnt     = 0;
    int          idle_cycles = 0;
    int          gap_left    = 0;
    int          stall_left  = 0;
    bit          steady      = 1'b0;

    shape_overlay_compositor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .dest_color   (dest_color),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_color    (out_color),
        .touched      (touched)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // One color channel: d + (s - d) * a / 255, truncated toward zero.
    function automatic logic [7:0] mix_level(input logic [7:0] s, input logic [7:0] d,
                                             input longint a);
        longint v;
        v = longint'(d) + ((longint'(s) - longint'(d)) * a) / longint'(ALPHA_FULL);
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // Alpha blend of the shape color over dst; returns whether the pixel is written.
    function automatic logic blend_pixel(input cfg_t c, input logic [31:0] dst,
                                         input longint a, output logic [31:0] res);
        res = dst;
        if (a <= 0)
            return 1'b0;
        if (a >= longint'(ALPHA_FULL))
        begin
            res = c.shape_color;
            return 1'b1;
        end
        res = {TOP_OPAQUE,
               mix_level(c.shape_color[23:16], dst[23:16], a),
               mix_level(c.shape_color[15:8], dst[15:8], a),
               mix_level(c.shape_color[7:0], dst[7:0], a)};
        return 1'b1;
    endfunction

    // Composed color of one pixel under the current shape settings.
    function automatic composed_t compose_pixel(input cfg_t c, input pixel_item_t p);
        composed_t r;
        longint    px, py, x0, y0, sa, sb, alpha, dx, dy, d2;
        longint    outer, inner2, gap, cov, ri, ri2;
        logic [31:0] res;
        logic        hit;
        px    = longint'(p.x);
        py    = longint'(p.y);
        x0    = longint'($signed(c.pos_x));
        y0    = longint'($signed(c.pos_y));
        sa    = longint'($signed(c.size_a));
        sb    = longint'($signed(c.size_b));
        alpha = longint'(c.opacity);
        dx    = px - x0;
        dy    = py - y0;
        d2    = dx * dx + dy * dy;
        res   = p.dest;
        hit   = 1'b0;
        if (px < SCREEN_W_DEF && py < SCREEN_H_DEF)
        begin
            case (c.mode)
                MODE_RECT:
                begin
                    if (px >= x0 && px < x0 + sa && py >= y0 && py < y0 + sb)
                        hit = blend_pixel(c, p.dest, alpha, res);
                end
                MODE_AA_DISC:
                begin
                    if (sa < 1)
                    begin
                        if (dx == 0 && dy == 0)
                        begin
                            res = c.shape_color;
                            hit = 1'b1;
                        end
                    end
                    else
                    begin
                        outer  = (sa + 1) * (sa + 1);
                        inner2 = (sa > 1) ? (sa - 1) * (sa - 1) : 0;
                        if (d2 <= inner2)
                        begin
                            res = c.shape_color;
                            hit = 1'b1;
                        end
                        else if (d2 <= outer)
                        begin
                            // Soft rim: coverage falls off with the distance past r.
                            gap = d2 - sa * sa;
                            if (gap <= 0)
                                cov = longint'(ALPHA_CORE);
                            else
                                cov = longint'(ALPHA_RIM_BASE) - (gap * RIM_SLOPE) / (2 * sa + 1);
                            if (cov < 0)
                                cov = 0;
                            hit = blend_pixel(c, p.dest, cov, res);
                        end
                    end
                end
                MODE_ALPHA_DISC:
                begin
                    if (sa < 1)
                    begin
                        if (dx == 0 && dy == 0)
                            hit = blend_pixel(c, p.dest, alpha, res);
                    end
                    else if (d2 <= (sa + 1) * (sa + 1))
                    begin
                        hit = blend_pixel(c, p.dest, (d2 > sa * sa) ? alpha / 2 : alpha, res);
                    end
                end
                default:
                begin
                    if (sa >= 0)
                    begin
                        ri  = sa - sb;
                        ri2 = (ri > 0) ? ri * ri : 0;
                        if (d2 <= sa * sa && d2 >= ri2)
                        begin
                            res = c.shape_color;
                            hit = 1'b1;
                        end
                    end
                end
            endcase
        end
        r.color   = res;
        r.touched = hit;
        return r;
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int rand_len();
        if ($urandom_range(0, 99) < 75)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    // Pixel driver: feeds queued words, with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        pixel_item_t next_px;
        bit          holding;
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            gap_left    <= 0;
        end
        else
        begin
            holding = pixel_valid;
            if (pixel_valid && pixel_ready)
            begin
                next_px.x    = pixel_x;
                next_px.y    = pixel_y;
                next_px.dest = dest_color;
                composed_q.push_back(compose_pixel(shape_cfg, next_px));
                n_taken++;
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (gap_left > 0)
                begin
                    gap_left    <= gap_left - 1;
                    pixel_valid <= 1'b0;
                end
                else if (pixel_q.size() > 0)
                begin
                    next_px = pixel_q.pop_front();
                    pixel_x     <= next_px.x;
                    pixel_y     <= next_px.y;
                    dest_color  <= next_px.dest;
                    pixel_valid <= 1'b1;
                    if (!steady && $urandom_range(0, 99) < 35)
                        gap_left <= rand_len();
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and comparison with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        composed_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (composed_q.size() == 0)
                begin
                    $error("result word with no pixel pending: out_color %h touched %b",
                           out_color, touched);
                    err_cnt++;
                end
                else
                begin
                    want = composed_q.pop_front();
                    if (out_color !== want.color)
                    begin
                        $error("out_color: expected %h, got %h", want.color, out_color);
                        err_cnt++;
                    end
                    if (touched !== want.touched)
                    begin
                        $error("touched: expected %b, got %b", want.touched, touched);
                        err_cnt++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                result_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 20)
            begin
                stall_left   <= rand_len() - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("shape_overlay_compositor_test: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Waits at a clock edge until every queued pixel is taken and has its result.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (!(n_taken == n_queued && composed_q.size() == 0));
    endtask

    // One register write; leaves cfg_valid high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_MODE:        shape_cfg.mode        = mode_t'(val[1:0]);
            CFG_POS_X:       shape_cfg.pos_x       = val[10:0];
            CFG_POS_Y:       shape_cfg.pos_y       = val[10:0];
            CFG_SIZE_A:      shape_cfg.size_a      = val[10:0];
            CFG_SIZE_B:      shape_cfg.size_b      = val[10:0];
            CFG_SHAPE_COLOR: shape_cfg.shape_color = val;
            CFG_OPACITY:     shape_cfg.opacity     = val[7:0];
            default:         ;
        endcase
    endtask

    // Rewrites the whole shape once the pipeline is empty.
    task automatic program_shape(input mode_t m, input int x0, input int y0, input int a,
                                 input int b, input logic [31:0] col, input logic [7:0] op);
        wait_drained();
        write_reg(CFG_MODE, 32'(m));
        write_reg(CFG_POS_X, 32'(x0));
        write_reg(CFG_POS_Y, 32'(y0));
        write_reg(CFG_SIZE_A, 32'(a));
        write_reg(CFG_SIZE_B, 32'(b));
        write_reg(CFG_SHAPE_COLOR, col);
        write_reg(CFG_OPACITY, 32'(op));
        cfg_valid <= 1'b0;
    endtask

    task automatic send(input int x, input int y, input logic [31:0] d);
        pixel_item_t p;
        p.x  = x[8:0];
        p.y  = y[8:0];
        p.dest = d;
        pixel_q.push_back(p);
        n_queued++;
    endtask

    // Screen coordinate within span of c, clipped to the screen.
    function automatic int near_coord(input int c, input int span);
        int v;
        v = c - span + int'($urandom_range(0, 2 * span));
        if (v < 0)
            v = 0;
        if (v > 511)
            v = 511;
        return v;
    endfunction

    initial
    begin : stimulus
        mode_t m;
        int    x0, y0, a, b, span, cx, cy, count;
        logic [7:0] op;
        shape_cfg.mode        = MODE_RECT;
        shape_cfg.pos_x       = '0;
        shape_cfg.pos_y       = '0;
        shape_cfg.size_a      = '0;
        shape_cfg.size_b      = '0;
        shape_cfg.shape_color = '0;
        shape_cfg.opacity     = ALPHA_FULL;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults give an empty rectangle.
        send(0, 0, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;

        // Rectangle edges with full alpha, then zero and partial alpha.
        program_shape(MODE_RECT, 10, 20, 5, 3, 32'h1234_5678, 8'd255);
        send(10, 20, $urandom);
        send(14, 22, $urandom);
        send(15, 20, $urandom);
        send(10, 23, $urandom);
        program_shape(MODE_RECT, 0, 0, 1023, 1023, 32'hA5C3_0F96, 8'd0);
        send(511, 511, 32'h0);
        program_shape(MODE_RECT, 0, 0, 1023, 1023, 32'h5A3C_F069, 8'd128);
        send(511, 0, 32'h00FF_00FF);
        send(0, 511, 32'hFFFF_FFFF);

        // Antialiased disc: zero radius, then core, rim at r, rim past r, outside.
        program_shape(MODE_AA_DISC, 100, 100, 0, 0, 32'h00C0_FFEE, 8'd255);
        send(100, 100, $urandom);
        send(101, 100, $urandom);
        program_shape(MODE_AA_DISC, 200, 200, 5, 0, 32'h0033_CC99, 8'd17);
        send(200, 200, $urandom);
        send(204, 200, $urandom);
        send(205, 200, $urandom);
        send(205, 203, $urandom);
        send(206, 200, $urandom);
        send(206, 201, $urandom);

        // Alpha disc: the opacity inside, half of it on the rim; negative radius.
        program_shape(MODE_ALPHA_DISC, 300, 50, 3, 0, 32'h7788_99AA, 8'd200);
        send(300, 50, $urandom);
        send(303, 52, $urandom);
        send(305, 50, $urandom);
        program_shape(MODE_ALPHA_DISC, 300, 50, -1024, 0, 32'hFFEE_DDCC, 8'd1);
        send(300, 50, $urandom);
        send(301, 50, $urandom);

        // Ring edges, a ring thicker than its radius, and a negative radius.
        program_shape(MODE_RING, 50, 60, 10, 3, 32'h0102_0304, 8'd255);
        send(60, 60, $urandom);
        send(57, 60, $urandom);
        send(56, 60, $urandom);
        program_shape(MODE_RING, 50, 60, 10, 1023, 32'h8070_6050, 8'd255);
        send(50, 60, $urandom);
        program_shape(MODE_RING, 1023, -1024, -1, -1024, 32'hFFFF_FFFF, 8'd255);
        send(511, 0, $urandom);

        // Random shapes, each with a burst of pixels mostly around the shape.
        while (n_queued < ITEM_GOAL)
        begin
            m = mode_t'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       x0 = -1024;
                1:       x0 = 1023;
                default: x0 = int'($urandom_range(0, 560)) - 24;
            endcase
            case ($urandom_range(0, 9))
                0:       y0 = -1024;
                1:       y0 = 1023;
                default: y0 = int'($urandom_range(0, 560)) - 24;
            endcase
            if (m == MODE_RECT)
            begin
                case ($urandom_range(0, 9))
                    0:       a = -int'($urandom_range(0, 1024));
                    1:       a = 1023;
                    default: a = int'($urandom_range(1, 200));
                endcase
                case ($urandom_range(0, 9))
                    0:       b = -int'($urandom_range(0, 1024));
                    1:       b = 1023;
                    default: b = int'($urandom_range(1, 200));
                endcase
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       a = -int'($urandom_range(1, 1024));
                    1:       a = 0;
                    2:       a = int'($urandom_range(200, 1023));
                    default: a = int'($urandom_range(1, 40));
                endcase
                case ($urandom_range(0, 9))
                    0:       b = -int'($urandom_range(1, 1024));
                    1:       b = 1023;
                    default: b = int'($urandom_range(0, 40));
                endcase
            end
            case ($urandom_range(0, 9))
                0:       op = 8'd0;
                1:       op = 8'd255;
                2:       op = 8'd1;
                3:       op = 8'd254;
                default: op = 8'($urandom_range(0, 255));
            endcase
            program_shape(m, x0, y0, a, b, $urandom, op);
            steady = ($urandom_range(0, 5) == 0);

            // Aim at the shape's footprint so edges and rims are hit often.
            if (m == MODE_RECT)
            begin
                span = ((a < 0) ? 0 : a / 2) + 3;
                cx   = x0 + span - 3;
                cy   = y0 + (((b < 0) ? 0 : b / 2));
                if (span > 600)
                    span = 600;
            end
            else
            begin
                span = ((a < 0) ? 0 : a) + 3;
                cx   = x0;
                cy   = y0;
                if (span > 600)
                    span = 600;
            end
            count = int'($urandom_range(20, 60));
            repeat (count)
            begin
                if ($urandom_range(0, 99) < 80)
                    send(near_coord(cx, span), near_coord(cy, span), $urandom);
                else
                    send(int'($urandom_range(0, 511)), int'($urandom_range(0, 511)), $urandom);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("shape_overlay_compositor_test: done, clean");
        else
            $display("shape_overlay_compositor_test: done, errors");
        $finish;
    end

endmodule
